// ----- sv/sci_pkg.sv -----
package sci_pkg;
    localparam int MAX_SIZE  = 16;
    localparam int FRAC_BITS = 31;
    localparam int IDX_W     = 4;
    localparam int ADDR_W    = 8;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 5;
    localparam int LOOP_W    = 16;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int ACC_W     = 40;

    localparam logic [CMD_W-1:0] CMD_LOAD_SIM  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_MEM  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_WGT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RUN       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_MEM  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_MASS = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DONE = 2'd2;

    localparam logic [0:0] CFG_SIZE = 1'b0;
    localparam logic [0:0] CFG_LOOP = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [STAT_W-1:0] status;
    } t_out;

    // controller -> datapath commands
    typedef struct packed {
        logic              wr_sim;     // write sim at addr_a with input value
        logic              wr_mem_in;  // write mem at addr_a with input value
        logic              wr_wgt;
        logic              rd_mem;     // take mem read data as the result
        logic [ADDR_W-1:0] addr_a;
        logic [IDX_W-1:0]  idx;        // vector index
        logic              acc_clr;
        logic              mass_acc;   // add Z*f of registered reads
        logic              mass_wr;    // store saturated acc to mass[idx]
        logic              term_acc;   // term = S*rho[idx], store scratch, add sum
        logic              div_start;  // start divide of scratch[idx] by sum
        logic              mem_wr_q;   // write quotient to mem at addr_a
        logic              flag_clr;
        logic              out_load;
        logic              out_run;
    } t_ctl;

    typedef struct packed {
        logic div_busy;
        logic sum_zero;
    } t_sts;
endpackage

// ----- sv/sci_if.sv -----
interface sci_in_if import sci_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sci_out_if import sci_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/sci_ram.sv -----
module sci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/sci_div.sv -----
module sci_div import sci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [ACC_W-1:0]  i_den,
    output logic              o_busy,
    output logic [DATA_W-1:0] o_quot
);
    // restoring divide of (num << FRAC_BITS) by den, one quotient bit a cycle
    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [ACC_W:0]   r_rem;
    logic [ACC_W-1:0] r_den;
    logic [DATA_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W:0]   n_shift;
    logic [ACC_W:0]   n_diff;

    assign n_shift = {r_rem[ACC_W-1:0], r_num[NUM_W-1]};
    assign n_diff  = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_start) begin
            r_num  <= {i_num, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            if (!n_diff[ACC_W]) begin
                r_rem  <= n_diff;
                r_quot <= {r_quot[DATA_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift;
                r_quot <= {r_quot[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
endmodule

// ----- sv/sci_datapath.sv -----
module sci_datapath import sci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [DATA_W-1:0] i_value,
    output t_sts              o_sts,
    output logic              o_flag,
    output logic [DATA_W-1:0] o_mem_rd,
    output logic [DATA_W-1:0] o_mass_rd
);
    logic [DATA_W-1:0] sim_rd, mem_rd, wgt_rd, quot;
    logic [DATA_W-1:0] r_mass [MAX_SIZE];
    logic [DATA_W-1:0] r_scr  [MAX_SIZE];
    logic [ACC_W-1:0]  r_acc;
    logic [2*DATA_W-1:0] n_prod_m, n_prod_t;
    logic [DATA_W:0]   n_pm, n_pt;
    logic [DATA_W-1:0] n_term;
    logic              r_flag;
    logic              div_busy;
    logic [DATA_W-1:0] mem_wdata;

    // a zero row sum clears the row instead of taking the quotient
    assign mem_wdata = i_ctl.mem_wr_q ? ((r_acc == '0) ? '0 : quot) : i_value;

    sci_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE*MAX_SIZE)) u_sim (
        .i_clk(i_clk), .i_we(i_ctl.wr_sim), .i_waddr(i_ctl.addr_a), .i_wdata(i_value),
        .i_raddr(i_ctl.addr_a), .o_rdata(sim_rd));
    sci_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE*MAX_SIZE)) u_mem (
        .i_clk(i_clk), .i_we(i_ctl.wr_mem_in | i_ctl.mem_wr_q), .i_waddr(i_ctl.addr_a),
        .i_wdata(mem_wdata), .i_raddr(i_ctl.addr_a), .o_rdata(mem_rd));
    sci_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_wgt (
        .i_clk(i_clk), .i_we(i_ctl.wr_wgt), .i_waddr(i_ctl.idx), .i_wdata(i_value),
        .i_raddr(i_ctl.idx), .o_rdata(wgt_rd));

    sci_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_ctl.div_start),
        .i_num(r_scr[i_ctl.idx]), .i_den(r_acc), .o_busy(div_busy), .o_quot(quot));

    // products truncated by FRAC_BITS; Q1.31 times Q1.31 fits in 33 bits
    assign n_prod_m = mem_rd * wgt_rd;
    assign n_prod_t = sim_rd * r_mass[i_ctl.idx];
    assign n_pm = n_prod_m[FRAC_BITS +: DATA_W+1];
    assign n_pt = n_prod_t[FRAC_BITS +: DATA_W+1];
    assign n_term = n_pt[DATA_W] ? '1 : n_pt[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
            for (int k = 0; k < MAX_SIZE; k++) begin
                r_mass[k] <= '0;
            end
        end else begin
            if (i_ctl.flag_clr) begin
                r_flag <= 1'b0;
            end else if (i_ctl.div_start && r_acc == '0) begin
                r_flag <= 1'b1;
            end
            if (i_ctl.mass_wr) begin
                r_mass[i_ctl.idx] <= (r_acc > ACC_W'({DATA_W{1'b1}})) ? '1 : r_acc[DATA_W-1:0];
            end
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.mass_acc) begin
            r_acc <= r_acc + ACC_W'(n_pm);
        end else if (i_ctl.term_acc) begin
            r_acc <= r_acc + ACC_W'(n_term);
        end
        if (i_ctl.term_acc) begin
            r_scr[i_ctl.idx] <= n_term;
        end
    end

    assign o_sts.div_busy = div_busy;
    assign o_sts.sum_zero = (r_acc == '0);
    assign o_flag    = r_flag;
    assign o_mem_rd  = mem_rd;
    assign o_mass_rd = r_mass[i_ctl.idx];
endmodule

// ----- sv/sci_ctrl.sv -----
module sci_ctrl import sci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_in               i_item,
    output logic              o_ready,
    input  logic              i_out_free,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [LOOP_W-1:0] i_loops,
    input  t_sts              i_sts,
    output t_ctl              o_ctl
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MRD   = 4'd1;  // issue Z[i][j], f[i] reads
    localparam logic [3:0] S_MACC  = 4'd2;  // accumulate product
    localparam logic [3:0] S_MWR   = 4'd3;
    localparam logic [3:0] S_TRD   = 4'd4;  // issue S[i][j] read
    localparam logic [3:0] S_TACC  = 4'd5;
    localparam logic [3:0] S_DST   = 4'd6;  // start divide for column j
    localparam logic [3:0] S_DWAIT = 4'd7;
    localparam logic [3:0] S_DWR   = 4'd8;
    localparam logic [3:0] S_RDOUT = 4'd9;  // memory read data lands
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]        r_st, n_st;
    logic [IDX_W-1:0]  r_i, r_j, n_i, n_j;
    logic [LOOP_W-1:0] r_k, n_k;
    logic [IDX_W-1:0]  last;
    logic              i_last, j_last;
    logic              acc_in;

    // active size minus one: zero acts as one, above MAX_SIZE acts as MAX_SIZE
    always_comb begin
        if (i_size == '0) begin
            last = '0;
        end else if (i_size > SIZE_W'(MAX_SIZE)) begin
            last = IDX_W'(MAX_SIZE - 1);
        end else begin
            last = IDX_W'(i_size - 1'b1);
        end
    end
    assign i_last = (r_i == last);
    assign j_last = (r_j == last);
    assign acc_in = i_valid && o_ready;

    always_comb begin
        n_st = r_st;
        n_i  = r_i;
        n_j  = r_j;
        n_k  = r_k;
        o_ready = 1'b0;
        o_ctl = '0;
        unique case (r_st)
            S_IDLE: begin
                o_ready = i_out_free;
                o_ctl.addr_a = {i_item.row, i_item.col};
                o_ctl.idx    = i_item.row;
                if (acc_in) begin
                    unique case (i_item.cmd)
                        CMD_LOAD_SIM:  o_ctl.wr_sim = 1'b1;
                        CMD_LOAD_MEM:  o_ctl.wr_mem_in = 1'b1;
                        CMD_LOAD_WGT:  o_ctl.wr_wgt = 1'b1;
                        CMD_READ_MEM:  n_st = S_RDOUT;
                        CMD_READ_MASS: o_ctl.out_load = 1'b1;
                        CMD_RUN: begin
                            o_ctl.flag_clr = 1'b1;
                            n_i = '0;
                            n_j = '0;
                            n_k = '0;
                            n_st = (i_loops == '0) ? S_DONE : S_MRD;
                            o_ctl.acc_clr = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDOUT: begin
                o_ctl.out_load = 1'b1;
                o_ctl.rd_mem = 1'b1;
                n_st = S_IDLE;
            end
            S_MRD: begin
                o_ctl.addr_a = {r_i, r_j};
                o_ctl.idx = r_i;
                n_st = S_MACC;
            end
            S_MACC: begin
                o_ctl.mass_acc = 1'b1;
                if (i_last) begin
                    n_st = S_MWR;
                end else begin
                    n_i = r_i + 1'b1;
                    n_st = S_MRD;
                end
            end
            S_MWR: begin
                o_ctl.idx = r_j;
                o_ctl.mass_wr = 1'b1;
                o_ctl.acc_clr = 1'b1;
                n_i = '0;
                if (j_last) begin
                    n_j = '0;
                    n_st = S_TRD;
                end else begin
                    n_j = r_j + 1'b1;
                    n_st = S_MRD;
                end
            end
            S_TRD: begin
                o_ctl.addr_a = {r_i, r_j};
                n_st = S_TACC;
            end
            S_TACC: begin
                o_ctl.idx = r_j;
                o_ctl.term_acc = 1'b1;
                if (j_last) begin
                    n_j = '0;
                    n_st = S_DST;
                end else begin
                    n_j = r_j + 1'b1;
                    n_st = S_TRD;
                end
            end
            S_DST: begin
                // a zero row sum skips the wait; the datapath writes zero
                o_ctl.idx = r_j;
                o_ctl.div_start = 1'b1;
                n_st = i_sts.sum_zero ? S_DWR : S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_sts.div_busy) begin
                    n_st = S_DWR;
                end
            end
            S_DWR: begin
                o_ctl.addr_a = {r_i, r_j};
                o_ctl.mem_wr_q = 1'b1;
                if (!j_last) begin
                    n_j = r_j + 1'b1;
                    n_st = S_DST;
                end else begin
                    n_j = '0;
                    o_ctl.acc_clr = 1'b1;
                    if (!i_last) begin
                        n_i = r_i + 1'b1;
                        n_st = S_TRD;
                    end else begin
                        n_i = '0;
                        n_k = r_k + 1'b1;
                        n_st = (r_k + 1'b1 == i_loops) ? S_DONE : S_MRD;
                    end
                end
            end
            S_DONE: begin
                o_ctl.out_load = 1'b1;
                o_ctl.out_run = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_i  <= '0;
            r_j  <= '0;
            r_k  <= '0;
        end else begin
            r_st <= n_st;
            r_i  <= n_i;
            r_j  <= n_j;
            r_k  <= n_k;
        end
    end
endmodule

// ----- sv/soft_clustering_iteration.sv -----
// Weighted soft clustering engine. Loads (similarity, membership, weight) take
// one item per cycle while idle and no result waits, and return nothing.
// A membership read returns its item through the registered RAM read and
// then the output register; a mass read returns on the next cycle. A run
// returns one item with status 1 (zero row sum seen) or 2. For size n, the
// mass pass issues and accumulates every entry and writes one mass per column,
// the row-term pass does the same per entry, and each new membership takes a
// start, a wait on a 63-step restoring divider, and a write. A row whose sum
// is zero skips the divide wait and is written as zeros. Indices cover the
// full 16x16 store, so every index is in range.
module soft_clustering_iteration import sci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sci_in_if.sink            in_ch,
    sci_out_if.source         out_ch,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [LOOP_W-1:0] i_cfg_data
);
    logic [SIZE_W-1:0] r_size;
    logic [LOOP_W-1:0] r_loops;
    t_ctl              ctl;
    t_sts              sts;
    logic              flag;
    logic [DATA_W-1:0] mem_rd, mass_rd;
    logic              r_ovalid;
    t_out              r_odata;
    logic              out_free;

    // hold the config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_W'(MAX_SIZE);
            r_loops <= LOOP_W'(1000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE: r_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_LOOP: r_loops <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accept only when the output register is free or draining
    assign out_free = !r_ovalid || out_ch.ready;

    sci_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_ch.valid), .i_item(in_ch.data),
        .o_ready(in_ch.ready), .i_out_free(out_free), .i_size(r_size), .i_loops(r_loops),
        .i_sts(sts), .o_ctl(ctl));

    sci_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_value(in_ch.data.value),
        .o_sts(sts), .o_flag(flag), .o_mem_rd(mem_rd), .o_mass_rd(mass_rd));

    // output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
        if (ctl.out_load) begin
            if (ctl.out_run) begin
                r_odata.read_value <= '0;
                r_odata.status     <= flag ? STAT_ZERO : STAT_DONE;
            end else begin
                r_odata.read_value <= ctl.rd_mem ? mem_rd : mass_rd;
                r_odata.status     <= STAT_OK;
            end
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;
endmodule

// ----- sv/sci_checker.sv -----
module sci_checker import sci_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [STAT_W-1:0] out_status,
    input logic [DATA_W-1:0] out_value
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result changed while stalled");
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("accept while result blocked");
    a_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status != STAT_OK |-> out_value == '0)
        else $error("run result nonzero");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_status != 2'd3)
        else $error("bad status");
endmodule

bind soft_clustering_iteration sci_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.data.status),
    .out_value(out_ch.data.read_value));

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import sci_pkg::*;

    // Codes the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    // Cycles with no item moved and no config write before the run is declared hung.
    // The slowest run here is size 16 with one iteration.
    localparam int STALL_LIMIT = 100000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [LOOP_W-1:0] i_cfg_data;

    sci_in_if  in_ch ();
    sci_out_if out_ch ();

    soft_clustering_iteration uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Clustering predictor: own copy of the stores and the registers.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] sim_m [MAX_SIZE*MAX_SIZE];
    logic [DATA_W-1:0] memb_m [MAX_SIZE*MAX_SIZE];
    logic [DATA_W-1:0] wgt_v [MAX_SIZE];
    logic [DATA_W-1:0] mass_v [MAX_SIZE];
    logic [DATA_W-1:0] term_v [MAX_SIZE];
    bit                zero_row_seen;
    logic [SIZE_W-1:0] size_reg;
    logic [LOOP_W-1:0] loop_reg;

    t_out expected_q[$];

    int mismatches;
    int unexpected;
    int loads_sent;
    int reads_sent;
    int runs_sent;
    int runs_zero;
    int results_seen;

    function automatic logic [63:0] fx_mul(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p >> FRAC_BITS;
    endfunction

    function automatic logic [31:0] sat32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic int active_n();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_SIZE) return MAX_SIZE;
        return int'(size_reg);
    endfunction

    // One fixed-point pass: masses from memberships, then normalized rows.
    task automatic iterate_once(input int n);
        logic [63:0] acc;
        for (int j = 0; j < n; j++) begin
            acc = 64'd0;
            for (int i = 0; i < n; i++)
                acc += fx_mul(memb_m[i*MAX_SIZE+j], wgt_v[i]);
            mass_v[j] = sat32(acc);
        end
        for (int i = 0; i < n; i++) begin
            acc = 64'd0;
            for (int j = 0; j < n; j++) begin
                term_v[j] = sat32(fx_mul(sim_m[i*MAX_SIZE+j], mass_v[j]));
                acc += {32'd0, term_v[j]};
            end
            for (int j = 0; j < n; j++)
                memb_m[i*MAX_SIZE+j] = (acc == 0) ? 32'd0 :
                    32'(({32'd0, term_v[j]} << FRAC_BITS) / acc);
            if (acc == 0) zero_row_seen = 1'b1;
        end
    endtask

    task automatic predict_item(input t_in it, output bit has_result, output t_out res);
        int slot;
        slot = int'(it.row) * MAX_SIZE + int'(it.col);
        has_result = 1'b0;
        res = '0;
        case (it.cmd)
            CMD_LOAD_SIM: sim_m[slot] = it.value;
            CMD_LOAD_MEM: memb_m[slot] = it.value;
            CMD_LOAD_WGT: wgt_v[it.row] = it.value;
            CMD_RUN: begin
                zero_row_seen = 1'b0;
                for (int k = 0; k < int'(loop_reg); k++)
                    iterate_once(active_n());
                res.read_value = '0;
                res.status = zero_row_seen ? STAT_ZERO : STAT_DONE;
                has_result = 1'b1;
            end
            CMD_READ_MEM: begin
                res.read_value = memb_m[slot];
                res.status = STAT_OK;
                has_result = 1'b1;
            end
            CMD_READ_MASS: begin
                res.read_value = mass_v[it.row];
                res.status = STAT_OK;
                has_result = 1'b1;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    int burst_left;
    bit no_gaps;

    // Drop valid and wait; with k zero, valid is left as it is.
    task automatic idle_cycles(input int k);
        if (k > 0) begin
            in_ch.valid <= 1'b0;
            repeat (k) @(posedge i_clk);
        end
    endtask

    task automatic send_item(input t_in it);
        bit   has_result;
        t_out res;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if (!no_gaps) idle_cycles($urandom_range(0, 6));
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        predict_item(it, has_result, res);
        if (has_result) expected_q.push_back(res);
        case (it.cmd)
            CMD_LOAD_SIM, CMD_LOAD_MEM, CMD_LOAD_WGT: loads_sent++;
            CMD_RUN: runs_sent++;
            CMD_READ_MEM, CMD_READ_MASS: reads_sent++;
            default: ;
        endcase
    endtask

    function automatic t_in mk(logic [CMD_W-1:0] cmd, int row, int col, logic [31:0] value);
        t_in it;
        it.cmd = cmd;
        it.row = row[IDX_W-1:0];
        it.col = col[IDX_W-1:0];
        it.value = value;
        return it;
    endfunction

    function automatic logic [31:0] rand_frac();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    // Hold the input low until every result is back, then let loads settle.
    task automatic wait_idle();
        idle_cycles(1);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [LOOP_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SIZE) size_reg = data[SIZE_W-1:0];
        else loop_reg = data;
    endtask

    task automatic set_config(input int size, input int loops);
        wait_idle();
        write_reg(CFG_SIZE, LOOP_W'(size));
        write_reg(CFG_LOOP, LOOP_W'(loops));
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall pattern picked at random, plus on-demand long holds.
    // ------------------------------------------------------------------
    int hold_requests;
    int hold_served;
    int hold_left;
    int rx_cnt;
    int rx_mode;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left <= 0;
            rx_cnt <= 0;
            rx_mode <= 0;
        end else begin
            rx_cnt <= rx_cnt + 1;
            if (rx_cnt % 600 == 0) rx_mode <= $urandom_range(0, 2);
            if (hold_served != hold_requests) begin
                hold_served <= hold_requests;
                hold_left <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= (rx_cnt % 4 != 0);
                    default: out_ch.ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // Compare each returned item with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("unexpected result: value %h status %0d",
                             out_ch.data.read_value, out_ch.data.status);
            end else begin
                want = expected_q.pop_front();
                if (out_ch.data.read_value !== want.read_value ||
                    out_ch.data.status !== want.status) begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                        $display("mismatch: expected value %h status %0d, got value %h status %0d",
                                 want.read_value, want.status,
                                 out_ch.data.read_value, out_ch.data.status);
                end
            end
        end
    end

    // Watchdog: count cycles in which no item moves on either channel and no config write happens.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("soft_clustering_iteration test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Fill every store entry so no run or read ever touches an unwritten one.
    task automatic test_preload();
        for (int r = 0; r < MAX_SIZE; r++)
            for (int c = 0; c < MAX_SIZE; c++) begin
                send_item(mk(CMD_LOAD_SIM, r, c, rand_frac()));
                send_item(mk(CMD_LOAD_MEM, r, c, rand_frac()));
            end
        for (int r = 0; r < MAX_SIZE; r++)
            send_item(mk(CMD_LOAD_WGT, r, 0, $urandom_range(1, 32'h8000_0000)));
    endtask

    // Field extremes, membership loads, both reads, a run, ignored codes.
    task automatic test_extremes();
        send_item(mk(CMD_LOAD_MEM, 0, 0, 32'd0));
        send_item(mk(CMD_LOAD_MEM, 15, 15, 32'h8000_0000));
        send_item(mk(CMD_LOAD_MEM, 15, 0, 32'hFFFF_FFFF));
        send_item(mk(CMD_LOAD_MEM, 0, 15, 32'h7FFF_FFFF));
        send_item(mk(CMD_READ_MEM, 0, 0, 32'hFFFF_FFFF));
        send_item(mk(CMD_READ_MEM, 15, 15, 32'd0));
        send_item(mk(CMD_READ_MEM, 15, 0, 32'd0));
        send_item(mk(CMD_READ_MEM, 0, 15, 32'd0));
        send_item(mk(CMD_READ_MASS, 0, 15, 32'd0));
        send_item(mk(CMD_READ_MASS, 15, 0, 32'd0));
        send_item(mk(CMD_UNUSED_6, 3, 4, 32'hFFFF_FFFF));
        send_item(mk(CMD_UNUSED_7, 15, 15, 32'h1234_5678));
        send_item(mk(CMD_READ_MEM, 15, 15, 32'd0));
        send_item(mk(CMD_RUN, 0, 0, 32'd0));
        send_item(mk(CMD_READ_MASS, 1, 0, 32'd0));
        send_item(mk(CMD_READ_MEM, 1, 1, 32'd0));
    endtask

    task automatic test_special_cases();
        // Zero row sum: clear similarity row 0 of a 2x2 problem.
        set_config(2, 1);
        send_item(mk(CMD_LOAD_SIM, 0, 0, 32'd0));
        send_item(mk(CMD_LOAD_SIM, 0, 1, 32'd0));
        send_item(mk(CMD_RUN, 0, 0, 32'd0));
        send_item(mk(CMD_READ_MEM, 0, 0, 32'd0));
        send_item(mk(CMD_READ_MEM, 0, 1, 32'd0));
        send_item(mk(CMD_LOAD_SIM, 0, 0, 32'h4000_0000));
        send_item(mk(CMD_LOAD_SIM, 0, 1, 32'h8000_0000));
        // Largest loop count: reads only, a run would take far too long.
        set_config(2, 65535);
        send_item(mk(CMD_READ_MASS, 0, 0, 32'd0));
        // Zero loop count leaves everything as it is.
        set_config(3, 0);
        send_item(mk(CMD_RUN, 0, 0, 32'd0));
        send_item(mk(CMD_READ_MEM, 0, 1, 32'd0));
        // Size zero acts as one, oversize acts as the full store.
        set_config(0, 2);
        send_item(mk(CMD_RUN, 0, 0, 32'd0));
        send_item(mk(CMD_READ_MASS, 0, 0, 32'd0));
        set_config(31, 1);
        send_item(mk(CMD_RUN, 0, 0, 32'd0));
        send_item(mk(CMD_READ_MASS, 15, 0, 32'd0));
        set_config(16, 1);
        send_item(mk(CMD_RUN, 0, 0, 32'd0));
    endtask

    // Stall the output for a long stretch while reads keep coming.
    task automatic test_backpressure();
        set_config(4, 1);
        no_gaps = 1'b1;
        hold_requests++;
        for (int k = 0; k < 60; k++)
            send_item(mk(k % 2 ? CMD_READ_MASS : CMD_READ_MEM,
                         $urandom_range(0, 15), $urandom_range(0, 15), $urandom));
        no_gaps = 1'b0;
    endtask

    task automatic test_random();
        int size;
        int loops;
        int pick;
        for (int phase = 0; phase < 4; phase++) begin
            case ($urandom_range(0, 5))
                0: size = 16;
                1: size = $urandom_range(17, 31);
                2: size = 0;
                default: size = $urandom_range(1, 6);
            endcase
            loops = (size == 0 || size > 8) ? $urandom_range(0, 1) : $urandom_range(0, 3);
            set_config(size, loops);
            no_gaps = (phase == 2);
            for (int k = 0; k < 206; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    send_item(mk(CMD_LOAD_SIM, $urandom_range(0, 15),
                                 $urandom_range(0, 15), rand_frac()));
                else if (pick < 40)
                    send_item(mk(CMD_LOAD_MEM, $urandom_range(0, 15),
                                 $urandom_range(0, 15), rand_frac()));
                else if (pick < 55)
                    send_item(mk(CMD_LOAD_WGT, $urandom_range(0, 15),
                                 $urandom_range(0, 15), rand_frac()));
                else if (pick < 57 && (size > 0 && size <= 8 || k % 4 == 0))
                    send_item(mk(CMD_RUN, $urandom_range(0, 15),
                                 $urandom_range(0, 15), $urandom));
                else if (pick < 77)
                    send_item(mk(CMD_READ_MEM, $urandom_range(0, 15),
                                 $urandom_range(0, 15), $urandom));
                else if (pick < 97)
                    send_item(mk(CMD_READ_MASS, $urandom_range(0, 15),
                                 $urandom_range(0, 15), $urandom));
                else
                    send_item(mk($urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7,
                                 $urandom_range(0, 15), $urandom_range(0, 15), $urandom));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_SIZE;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        size_reg = 5'd16;
        loop_reg = 16'd1000;
        zero_row_seen = 1'b0;
        for (int k = 0; k < MAX_SIZE*MAX_SIZE; k++) begin
            sim_m[k] = '0;
            memb_m[k] = '0;
        end
        for (int k = 0; k < MAX_SIZE; k++) begin
            wgt_v[k] = '0;
            mass_v[k] = '0;
            term_v[k] = '0;
        end
        burst_left = 0;
        no_gaps = 1'b0;
        hold_requests = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Small problem first so the directed run stays short.
        set_config(3, 2);
        test_preload();
        test_extremes();
        test_special_cases();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (200) @(posedge i_clk);

        $display("covered %0d loads, %0d reads, %0d runs; %0d results checked",
                 loads_sent, reads_sent, runs_sent, results_seen);
        $display("sizes 0..31 and loop counts 0..65535 written; %0d mismatches, %0d extra, %0d missing",
                 mismatches, unexpected, expected_q.size());
        if (mismatches == 0 && unexpected == 0 && expected_q.size() == 0) begin
            $display("soft_clustering_iteration test passed");
        end else begin
            $display("soft_clustering_iteration test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sci_pkg.sv
sv/sci_if.sv
sv/sci_ram.sv
sv/sci_div.sv
sv/sci_datapath.sv
sv/sci_ctrl.sv
sv/soft_clustering_iteration.sv
sv/sci_checker.sv
bench/tb_top.sv
